@@ src/dedc_pkg.sv @@
// ----------------------------------------------------------------------------
// dedc_pkg
// Shared types, constants and the CRC-8 word update for the detector event
// deframer and checker.
// ----------------------------------------------------------------------------
package dedc_pkg;

  // Default width of the per-event hit counters
  localparam int HIT_COUNT_WIDTH_DEF = 16;

  // Link word layout
  localparam int          WORD_W        = 40;
  localparam int          CHIP_ID_W     = 17;
  localparam logic [14:0] SYNC_PATTERN  = 15'h3C5C;
  localparam logic [7:0]  CRC_POLY      = 8'h2F;

  // Sync word kinds (bits 23:22)
  localparam logic [1:0]  KIND_HEADER   = 2'd0;

  // Chip id after reset
  localparam logic [CHIP_ID_W-1:0] CHIP_ID_RESET = 17'd109517;

  // Hit count rules
  localparam int          HIT_FULL_MIN  = 200;
  localparam logic [8:0]  EXP_FULL      = 9'd256;
  localparam logic [15:0] HIT_SAT       = 16'hFFFF;

  // Commands
  localparam logic        CMD_WORD      = 1'b0;
  localparam logic        CMD_END       = 1'b1;

  // Register map
  localparam int          PADDR_W       = 3;
  localparam logic        REG_CHIP_ID   = 1'b0;

  // Input word
  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] link_word;
  } in_t;

  // Event result
  typedef struct packed {
    logic [31:0] event_number;
    logic        discarded;
    logic [11:0] bunch_id;
    logic [1:0]  header_kind;
    logic [7:0]  trigger_count;
    logic [8:0]  expected_hits;
    logic [15:0] received_hits;
    logic [15:0] good_hits;
    logic [1:0]  buffer_state;
    logic        crc_error;
    logic        hits_missing;
    logic        hit_error_seen;
  } out_t;

  // CRC-8 over one 40-bit word, MSB first. Linear, so it flattens to an XOR
  // network of depth about log2 of the taps.
  function automatic logic [7:0] crc_word(input logic [7:0] c_in,
                                          input logic [WORD_W-1:0] w);
    logic [7:0] c;
    logic       fb;
    c = c_in;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

@@ src/detector_event_deframer_checker.sv @@
// ----------------------------------------------------------------------------
// detector_event_deframer_checker
// Classifies 40-bit link words, assembles events with CRC-8 and hit counts,
// and reports each completed event when the next header or end arrives.
// ----------------------------------------------------------------------------
// One link word is taken every clock while the skid entry is empty. All
// classification, CRC and counter updates are combinational between the
// input handshake and the result register. A result is registered when
// the word that releases it (the next header or the end command) is taken,
// into the skid entry if the output register is full; input stalls only
// while both hold undelivered results. No clearing pass is needed after reset.
module detector_event_deframer_checker #(
  parameter int HIT_COUNT_WIDTH = dedc_pkg::HIT_COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dedc_pkg::in_t                in_data,
  // event results
  output logic                         out_valid,
  input  logic                         out_ready,
  output dedc_pkg::out_t               out_data,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dedc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef logic [HIT_COUNT_WIDTH-1:0] cnt_t;

  // Configuration
  logic [dedc_pkg::CHIP_ID_W-1:0] chip_id_r;

  // Event state
  logic        synced_r,   synced_nxt;
  logic        inside_r,   inside_nxt;
  logic        held_r,     held_nxt;
  logic        first_r,    first_nxt;
  logic [7:0]  last_l1_r,  last_l1_nxt;
  logic [31:0] events_r,   events_nxt;
  logic [7:0]  crc_r,      crc_nxt;
  cnt_t        hits_r,     hits_nxt;
  cnt_t        good_r,     good_nxt;
  logic        err_r,      err_nxt;
  logic [21:0] hdr_r,      hdr_nxt;
  logic [8:0]  h_exp_r,    h_exp_nxt;
  logic [1:0]  h_buf_r,    h_buf_nxt;
  logic        h_crc_r,    h_crc_nxt;
  logic        h_miss_r,   h_miss_nxt;

  // Output register and skid entry
  logic           out_valid_r;
  dedc_pkg::out_t out_r;
  logic           skid_valid_r;
  dedc_pkg::out_t skid_r;

  // Word decode
  logic [dedc_pkg::WORD_W-1:0] w;
  logic        is_data, is_sync, is_hdr, is_trl;
  logic        jump;
  logic [7:0]  crc_trl;
  logic [8:0]  exp_v;
  logic [31:0] hits_ext, good_ext;
  logic        res_valid;
  dedc_pkg::out_t res;

  logic in_fire, out_fire, cfg_wr;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == dedc_pkg::REG_CHIP_ID) ?
                     {{(32 - dedc_pkg::CHIP_ID_W){1'b0}}, chip_id_r} : 32'h0;

  // Classification
  assign w       = in_data.link_word;
  assign is_data = w[39];
  assign is_sync = !is_data && (w[38:24] == dedc_pkg::SYNC_PATTERN);
  assign is_hdr  = is_sync && (w[23:22] == dedc_pkg::KIND_HEADER);
  assign is_trl  = !is_data && !is_sync && (w[38:22] == chip_id_r);

  // Trailer CRC and expected hits
  assign crc_trl = dedc_pkg::crc_word(crc_r, w);
  always_comb begin
    exp_v = {1'b0, w[15:8]};
    if (w[15:8] == 8'h00 && hits_r >= cnt_t'(dedc_pkg::HIT_FULL_MIN)) begin
      exp_v = dedc_pkg::EXP_FULL;
    end
  end

  // Trigger jump check: skipped on the first header and after an abandoned event
  assign jump = !first_r && !inside_r && (w[21:14] != last_l1_r + 8'd1);

  // Result fields come from the held event
  assign hits_ext = 32'(hits_r);
  assign good_ext = 32'(good_r);
  always_comb begin
    res.event_number   = events_r;
    res.discarded      = (in_data.command == dedc_pkg::CMD_WORD) && jump;
    res.bunch_id       = hdr_r[11:0];
    res.header_kind    = hdr_r[13:12];
    res.trigger_count  = hdr_r[21:14];
    res.expected_hits  = h_exp_r;
    res.received_hits  = (hits_ext > 32'(dedc_pkg::HIT_SAT)) ? dedc_pkg::HIT_SAT
                                                              : hits_ext[15:0];
    res.good_hits      = (good_ext > 32'(dedc_pkg::HIT_SAT)) ? dedc_pkg::HIT_SAT
                                                              : good_ext[15:0];
    res.buffer_state   = h_buf_r;
    res.crc_error      = h_crc_r;
    res.hits_missing   = h_miss_r;
    res.hit_error_seen = err_r;
  end

  // Next state for one accepted word
  always_comb begin
    synced_nxt  = synced_r;
    inside_nxt  = inside_r;
    held_nxt    = held_r;
    first_nxt   = first_r;
    last_l1_nxt = last_l1_r;
    events_nxt  = events_r;
    crc_nxt     = crc_r;
    hits_nxt    = hits_r;
    good_nxt    = good_r;
    err_nxt     = err_r;
    hdr_nxt     = hdr_r;
    h_exp_nxt   = h_exp_r;
    h_buf_nxt   = h_buf_r;
    h_crc_nxt   = h_crc_r;
    h_miss_nxt  = h_miss_r;
    res_valid   = 1'b0;
    priority if (in_data.command == dedc_pkg::CMD_END) begin
      // flush the held event, then back to reset values
      res_valid   = held_r;
      synced_nxt  = 1'b0;
      inside_nxt  = 1'b0;
      held_nxt    = 1'b0;
      first_nxt   = 1'b1;
      last_l1_nxt = 8'h00;
      events_nxt  = 32'h0;
      crc_nxt     = 8'h00;
      hits_nxt    = '0;
      good_nxt    = '0;
      err_nxt     = 1'b0;
      hdr_nxt     = 22'h0;
      h_exp_nxt   = 9'h0;
      h_buf_nxt   = 2'h0;
      h_crc_nxt   = 1'b0;
      h_miss_nxt  = 1'b0;
    end else if (!synced_r && !is_hdr) begin
      // dropped until the first header
    end else if (is_data) begin
      synced_nxt = 1'b1;
      if (inside_r) begin
        if (hits_r != '1) hits_nxt = hits_r + cnt_t'(1);
        if (w[38:37] < 2'd2) begin
          if (good_r != '1) good_nxt = good_r + cnt_t'(1);
        end else begin
          err_nxt = 1'b1;
        end
        crc_nxt = crc_trl;
      end
    end else if (is_hdr) begin
      synced_nxt  = 1'b1;
      first_nxt   = 1'b0;
      last_l1_nxt = w[21:14];
      if (held_r) begin
        res_valid = 1'b1;
        held_nxt  = 1'b0;
        if (!jump) events_nxt = events_r + 32'd1;
      end
      inside_nxt = 1'b1;
      hits_nxt   = '0;
      good_nxt   = '0;
      err_nxt    = 1'b0;
      crc_nxt    = dedc_pkg::crc_word(8'h00, w);
      hdr_nxt    = w[21:0];
    end else if (is_trl && inside_r) begin
      crc_nxt    = crc_trl;
      h_exp_nxt  = exp_v;
      h_buf_nxt  = w[21:20];
      h_crc_nxt  = (crc_trl != 8'h00);
      h_miss_nxt = (32'(exp_v) > hits_ext);
      held_nxt   = 1'b1;
      inside_nxt = 1'b0;
    end else begin
      // filler, unknown, or trailer outside an event
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r <= dedc_pkg::CHIP_ID_RESET;
      synced_r  <= 1'b0;
      inside_r  <= 1'b0;
      held_r    <= 1'b0;
      first_r   <= 1'b1;
      last_l1_r <= 8'h00;
      events_r  <= 32'h0;
      crc_r     <= 8'h00;
      hits_r    <= '0;
      good_r    <= '0;
      err_r     <= 1'b0;
      hdr_r     <= 22'h0;
      h_exp_r   <= 9'h0;
      h_buf_r   <= 2'h0;
      h_crc_r   <= 1'b0;
      h_miss_r  <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == dedc_pkg::REG_CHIP_ID) begin
        chip_id_r <= pwdata[dedc_pkg::CHIP_ID_W-1:0];
      end
      if (in_fire) begin
        synced_r  <= synced_nxt;
        inside_r  <= inside_nxt;
        held_r    <= held_nxt;
        first_r   <= first_nxt;
        last_l1_r <= last_l1_nxt;
        events_r  <= events_nxt;
        crc_r     <= crc_nxt;
        hits_r    <= hits_nxt;
        good_r    <= good_nxt;
        err_r     <= err_nxt;
        hdr_r     <= hdr_nxt;
        h_exp_r   <= h_exp_nxt;
        h_buf_r   <= h_buf_nxt;
        h_crc_r   <= h_crc_nxt;
        h_miss_r  <= h_miss_nxt;
      end
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

@@ src/dedc_checker.sv @@
// ----------------------------------------------------------------------------
// dedc_checker
// Port-level assertions for the detector event deframer and checker.
// ----------------------------------------------------------------------------
module dedc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input dedc_pkg::in_t                in_data,
  input logic                         out_valid,
  input logic                         out_ready,
  input dedc_pkg::out_t               out_data,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [dedc_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);

  // A pending result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the word was taken");

  // Input stalls only while results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending result");

  // Missing-hits flag agrees with the reported counts
  a_miss_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hits_missing ==
                   (16'(out_data.expected_hits) > out_data.received_hits)))
    else $error("hits_missing inconsistent with counts");

  // The 256 reading only happens with 200 or more hits
  a_exp_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.expected_hits[8] |->
      (out_data.expected_hits[7:0] == 8'h00 && out_data.received_hits >= 16'd200))
    else $error("expected_hits of 256 without enough hits");

  // Chip id register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[2] == dedc_pkg::REG_CHIP_ID |=>
      (paddr[2] != dedc_pkg::REG_CHIP_ID ||
       prdata[dedc_pkg::CHIP_ID_W-1:0] == $past(pwdata[dedc_pkg::CHIP_ID_W-1:0])))
    else $error("chip id readback mismatch");

endmodule

bind detector_event_deframer_checker dedc_checker u_dedc_checker (.*);
